// ===== rtl/ppf_pkg.sv =====
package ppf_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int COORD_BITS_DEF   = 24;

  localparam int Q_BITS     = 16;
  localparam int T_BITS     = 17;
  localparam logic [T_BITS-1:0] T_ONE  = 17'h10000;
  localparam logic [T_BITS-1:0] T_HALF = 17'h08000;

  localparam int DIST_BITS = 24;
  localparam logic [DIST_BITS-1:0] DIST_MAX = 24'hFFFFFF;

  // Each distance component is clamped to 2^24 before squaring.
  localparam int CLAMP_BITS = 25;
  localparam logic [CLAMP_BITS-1:0] DIST_CLAMP = 25'h1000000;
  localparam int RAD_BITS  = 2 * CLAMP_BITS;
  localparam int ROOT_BITS = CLAMP_BITS;

  localparam int CHAIN_BITS = 32;
  localparam int LEN_BITS   = 24;
  localparam int SLOT_BITS  = 6;
  localparam int COUNT_BITS = 7;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_POINT = 1'b1;

  localparam logic [7:0] CLS_LOW_VEG  = 8'd3;
  localparam logic [7:0] CLS_MID_VEG  = 8'd4;
  localparam logic [7:0] CLS_HIGH_VEG = 8'd5;
  localparam logic [7:0] CLS_EXTRA    = 8'd13;

  localparam int CFG_ADDR_BITS = 4;
  localparam logic [1:0] REG_SEG_COUNT = 2'd0;
  localparam logic [1:0] REG_RADIUS    = 2'd1;
  localparam logic [1:0] REG_ADVISORY  = 2'd2;
  localparam logic [1:0] REG_USE_CLASS = 2'd3;

  typedef enum logic [1:0] {
    TM_DIV  = 2'd0,
    TM_ZERO = 2'd1,
    TM_FULL = 2'd2
  } tmode_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

// ===== rtl/ppf_if.sv =====
interface ppf_in_if #(
  parameter int COORD_BITS = ppf_pkg::COORD_BITS_DEF
);
  logic                                  valid;
  logic                                  ready;
  logic                                  operation;
  logic [ppf_pkg::SLOT_BITS-1:0]         seg_slot;
  logic signed [COORD_BITS-1:0]          pos_x;
  logic signed [COORD_BITS-1:0]          pos_y;
  logic signed [COORD_BITS-1:0]          pos_z;
  logic signed [COORD_BITS-1:0]          end_x;
  logic signed [COORD_BITS-1:0]          end_y;
  logic signed [COORD_BITS-1:0]          end_z;
  logic [ppf_pkg::CHAIN_BITS-1:0]        start_chainage;
  logic [ppf_pkg::LEN_BITS-1:0]          seg_horiz_length;
  logic                                  has_class;
  logic [7:0]                            class_code;

  modport source (
    output valid, operation, seg_slot, pos_x, pos_y, pos_z, end_x, end_y, end_z,
           start_chainage, seg_horiz_length, has_class, class_code,
    input  ready
  );
  modport sink (
    input  valid, operation, seg_slot, pos_x, pos_y, pos_z, end_x, end_y, end_z,
           start_chainage, seg_horiz_length, has_class, class_code,
    output ready
  );
endinterface

interface ppf_out_if;
  logic                            valid;
  logic                            ready;
  logic                            keep;
  logic                            found_segment;
  logic [ppf_pkg::SLOT_BITS-1:0]   best_segment;
  logic [ppf_pkg::CHAIN_BITS-1:0]  chainage;
  logic [ppf_pkg::DIST_BITS-1:0]   horiz_distance;
  logic [ppf_pkg::DIST_BITS-1:0]   dist_3d;

  modport source (
    output valid, keep, found_segment, best_segment, chainage, horiz_distance, dist_3d,
    input  ready
  );
  modport sink (
    input  valid, keep, found_segment, best_segment, chainage, horiz_distance, dist_3d,
    output ready
  );
endinterface

// ===== rtl/ppf_div_cell.sv =====
module ppf_div_cell #(
  parameter int REM_W = 52,
  parameter int TAG_W = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_v,
  input  logic [REM_W-1:0]               in_rem,
  input  logic [REM_W-1:0]               in_den,
  input  logic [ppf_pkg::Q_BITS-1:0]     in_q,
  input  logic [TAG_W-1:0]               in_tag,
  output logic                           out_v,
  output logic [REM_W-1:0]               out_rem,
  output logic [REM_W-1:0]               out_den,
  output logic [ppf_pkg::Q_BITS-1:0]     out_q,
  output logic [TAG_W-1:0]               out_tag
);

  // One restoring division step: one quotient bit per cell.
  logic [REM_W:0]                rem2;
  logic                          take;
  logic [REM_W-1:0]              rem_nxt;
  logic [ppf_pkg::Q_BITS-1:0]    q_nxt;

  always_comb begin
    rem2    = {in_rem, 1'b0};
    take    = (rem2 >= {1'b0, in_den});
    rem_nxt = take ? REM_W'(rem2 - {1'b0, in_den}) : REM_W'(rem2);
    q_nxt   = {in_q[ppf_pkg::Q_BITS-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v <= 1'b0;
    end else begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    out_rem <= rem_nxt;
    out_den <= in_den;
    out_q   <= q_nxt;
    out_tag <= in_tag;
  end

endmodule

// ===== rtl/ppf_sqrt_cell.sv =====
module ppf_sqrt_cell #(
  parameter int TAG_W = 8
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_v,
  input  logic [1:0][ppf_pkg::RAD_BITS-1:0]             in_rad,
  input  logic [1:0][ppf_pkg::ROOT_BITS+1:0]            in_r,
  input  logic [1:0][ppf_pkg::ROOT_BITS-1:0]            in_q,
  input  logic [TAG_W-1:0]                              in_tag,
  output logic                                          out_v,
  output logic [1:0][ppf_pkg::RAD_BITS-1:0]             out_rad,
  output logic [1:0][ppf_pkg::ROOT_BITS+1:0]            out_r,
  output logic [1:0][ppf_pkg::ROOT_BITS-1:0]            out_q,
  output logic [TAG_W-1:0]                              out_tag
);

  localparam int RW = ppf_pkg::ROOT_BITS + 2;

  // One root bit per cell for two lanes: horizontal and 3D.
  logic [1:0][RW+1:0]                    rt;
  logic [1:0][RW+1:0]                    trial;
  logic [1:0]                            take;
  logic [1:0][RW-1:0]                    r_nxt;
  logic [1:0][ppf_pkg::ROOT_BITS-1:0]    q_nxt;
  logic [1:0][ppf_pkg::RAD_BITS-1:0]     rad_nxt;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      rt[k]      = {in_r[k], in_rad[k][ppf_pkg::RAD_BITS-1 -: 2]};
      trial[k]   = (RW+2)'({in_q[k], 2'b01});
      take[k]    = (rt[k] >= trial[k]);
      r_nxt[k]   = take[k] ? RW'(rt[k] - trial[k]) : RW'(rt[k]);
      q_nxt[k]   = {in_q[k][ppf_pkg::ROOT_BITS-2:0], take[k]};
      rad_nxt[k] = {in_rad[k][ppf_pkg::RAD_BITS-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v <= 1'b0;
    end else begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    out_rad <= rad_nxt;
    out_r   <= r_nxt;
    out_q   <= q_nxt;
    out_tag <= in_tag;
  end

endmodule

// ===== rtl/point_polyline_projection_filter.sv =====
// A point beat gives one result after the search over its segments, or with no search at all
// with a segment count of zero; a load beat gives no result. A beat is taken only in IDLE,
// so a new point is not accepted until the last result has gone into the output register,
// which may wait on the receiver; within a search the evaluation chain takes one segment per
// cycle from the single read port of the segment memory.
// Reset (synchronous, rst_n low) clears the config registers, valid flags and control state;
// data registers and the segment memory keep their contents; memory is undefined until loaded.
module point_polyline_projection_filter #(
  parameter int MAX_SEGMENTS = ppf_pkg::MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = ppf_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  ppf_in_if.sink                                in_ch,
  ppf_out_if.source                             out_ch,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ppf_pkg::CFG_ADDR_BITS-1:0]     paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int CB   = COORD_BITS;
  localparam int AW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW   = $clog2(MAX_SEGMENTS + 1);
  // Product, sum and distance magnitude widths for the projection terms.
  localparam int PW   = 2 * CB + 2;
  localparam int SW   = PW + 2;
  localparam int MW   = (CB + 2 > ppf_pkg::CLAMP_BITS) ? CB + 2 : ppf_pkg::CLAMP_BITS;
  localparam int DIV_STEPS  = ppf_pkg::Q_BITS;
  localparam int SQRT_STEPS = ppf_pkg::ROOT_BITS;
  localparam int CHB  = ppf_pkg::CHAIN_BITS;
  localparam int LB   = ppf_pkg::LEN_BITS;
  localparam int RADB = ppf_pkg::RAD_BITS;
  localparam int RTB  = ppf_pkg::ROOT_BITS;
  localparam int ROW_W = 6 * CB + CHB + LB;

  // Side bundle carried along the chain: index, chainage, length, w and v vectors.
  localparam int OFF_CH = AW;
  localparam int OFF_LN = AW + CHB;
  localparam int OFF_W  = AW + CHB + LB;
  localparam int OFF_V  = OFF_W + 3 * (CB + 1);
  localparam int BW     = OFF_V + 3 * (CB + 1);
  localparam int TW     = BW + 2;
  localparam int QTW    = CHB + AW;

  // ---------------------------------------------------------------------------------------
  // Configuration registers. pready is tied high, so a write lands in the access cycle.
  // ---------------------------------------------------------------------------------------
  logic [ppf_pkg::COUNT_BITS-1:0]  seg_count_r;
  logic [ppf_pkg::DIST_BITS-1:0]   radius_r;
  logic [ppf_pkg::DIST_BITS-1:0]   advisory_r;
  logic                            use_cls_r;
  logic                            cfg_wr;
  logic [1:0]                      cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= '0;
      radius_r    <= '0;
      advisory_r  <= '0;
      use_cls_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ppf_pkg::REG_SEG_COUNT: seg_count_r <= pwdata[ppf_pkg::COUNT_BITS-1:0];
        ppf_pkg::REG_RADIUS:    radius_r    <= pwdata[ppf_pkg::DIST_BITS-1:0];
        ppf_pkg::REG_ADVISORY:  advisory_r  <= pwdata[ppf_pkg::DIST_BITS-1:0];
        ppf_pkg::REG_USE_CLASS: use_cls_r   <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      ppf_pkg::REG_SEG_COUNT: prdata = 32'(seg_count_r);
      ppf_pkg::REG_RADIUS:    prdata = 32'(radius_r);
      ppf_pkg::REG_ADVISORY:  prdata = 32'(advisory_r);
      ppf_pkg::REG_USE_CLASS: prdata = 32'(use_cls_r);
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer. A load beat writes one memory row in IDLE. A point beat starts a search, or goes
  // straight to DONE with a count of zero: RUN issues one segment read per cycle and counts
  // results leaving the chain, DONE waits for the output register to be free.
  // ---------------------------------------------------------------------------------------
  ppf_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   n_r, iss_r, ret_r;
  logic            in_acc, is_load, is_point, slot_ok, rd_en, pipe_v, out_v_r, out_load;

  logic signed [CB-1:0]  px_r, py_r, pz_r;
  logic                  hc_r;
  logic [7:0]            cls_r;

  logic                            best_found_r;
  logic [AW-1:0]                   best_idx_r;
  logic [CHB-1:0]                  best_ch_r;
  logic [ppf_pkg::DIST_BITS-1:0]   best_dh_r, best_d3_r;

  logic                            o_keep_r, o_found_r;
  logic [ppf_pkg::SLOT_BITS-1:0]   o_idx_r;
  logic [CHB-1:0]                  o_ch_r;
  logic [ppf_pkg::DIST_BITS-1:0]   o_dh_r, o_d3_r;

  logic [CW-1:0]                   n_eff;
  logic                            veg, keep_now;

  assign in_ch.ready = (state_r == ppf_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_load     = in_acc && (in_ch.operation == ppf_pkg::OP_LOAD);
  assign is_point    = in_acc && (in_ch.operation == ppf_pkg::OP_POINT);
  assign slot_ok     = (32'(in_ch.seg_slot) < 32'(MAX_SEGMENTS));
  assign rd_en       = (state_r == ppf_pkg::ST_RUN) && (iss_r < n_r);
  assign out_load    = (state_r == ppf_pkg::ST_DONE) && (!out_v_r || out_ch.ready);

  // A count above the memory depth searches the whole memory.
  assign n_eff = (32'(seg_count_r) > 32'(MAX_SEGMENTS)) ? CW'(MAX_SEGMENTS)
                                                        : CW'(seg_count_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppf_pkg::ST_IDLE: begin
        if (is_point) begin
          state_nxt = (n_eff == '0) ? ppf_pkg::ST_DONE : ppf_pkg::ST_RUN;
        end
      end
      ppf_pkg::ST_RUN: begin
        if (pipe_v && (ret_r == n_r - CW'(1))) begin
          state_nxt = ppf_pkg::ST_DONE;
        end
      end
      ppf_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = ppf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ppf_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Segment memory: one row per slot, written by load beats, read once per issued segment.
  // ---------------------------------------------------------------------------------------
  logic [ROW_W-1:0] seg_mem [MAX_SEGMENTS];
  logic [ROW_W-1:0] row_r;
  logic [AW-1:0]    row_idx_r;
  logic             s0_v_r;

  always_ff @(posedge clk) begin
    if (is_load && slot_ok) begin
      seg_mem[AW'(in_ch.seg_slot)] <= {in_ch.seg_horiz_length, in_ch.start_chainage,
                                       in_ch.end_z, in_ch.end_y, in_ch.end_x,
                                       in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
    end
    row_r     <= seg_mem[iss_r[AW-1:0]];
    row_idx_r <= iss_r[AW-1:0];
  end

  // ---------------------------------------------------------------------------------------
  // Front stages: difference vectors, products, dot product and squared length.
  // ---------------------------------------------------------------------------------------
  logic signed [CB:0]    v1_r [3];
  logic signed [CB:0]    w1_r [3];
  logic [AW+CHB+LB-1:0]  side1_r;
  logic                  s1_v_r;
  logic signed [CB:0]    p_k [3];

  assign p_k[0] = (CB+1)'(px_r);
  assign p_k[1] = (CB+1)'(py_r);
  assign p_k[2] = (CB+1)'(pz_r);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      v1_r[k] <= (CB+1)'($signed(row_r[(3+k)*CB +: CB]))
               - (CB+1)'($signed(row_r[k*CB +: CB]));
      w1_r[k] <= p_k[k] - (CB+1)'($signed(row_r[k*CB +: CB]));
    end
    side1_r <= {row_r[ROW_W-1 -: LB], row_r[6*CB +: CHB], row_idx_r};
  end

  logic [PW-1:0]  sqv2_r [3];
  logic [PW-1:0]  dot2_r [3];
  logic [2:0]     neg2_r;
  logic [BW-1:0]  b2_r;
  logic           s2_v_r;
  logic [CB:0]    vm1 [3];
  logic [CB:0]    wm1 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vm1[k] = v1_r[k][CB] ? unsigned'(-v1_r[k]) : unsigned'(v1_r[k]);
      wm1[k] = w1_r[k][CB] ? unsigned'(-w1_r[k]) : unsigned'(w1_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sqv2_r[k] <= vm1[k] * vm1[k];
      dot2_r[k] <= wm1[k] * vm1[k];
      neg2_r[k] <= v1_r[k][CB] ^ w1_r[k][CB];
    end
    b2_r <= {v1_r[2], v1_r[1], v1_r[0], w1_r[2], w1_r[1], w1_r[0], side1_r};
  end

  logic [SW-1:0]          len3_r;
  logic signed [SW:0]     dot3_r;
  logic [BW-1:0]          b3_r;
  logic                   s3_v_r;
  logic signed [SW:0]     dterm [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dterm[k] = neg2_r[k] ? -$signed((SW+1)'(dot2_r[k])) : $signed((SW+1)'(dot2_r[k]));
    end
  end

  always_ff @(posedge clk) begin
    len3_r <= SW'(sqv2_r[0]) + SW'(sqv2_r[1]) + SW'(sqv2_r[2]);
    dot3_r <= dterm[0] + dterm[1] + dterm[2];
    b3_r   <= b2_r;
  end

  // The clamp decision: zero length or a point behind the start gives 0, beyond the end 1.
  ppf_pkg::tmode_t  mode4_r;
  logic [SW-1:0]    rem4_r, len4_r;
  logic [BW-1:0]    b4_r;
  logic             s4_v_r;

  always_ff @(posedge clk) begin
    if ((len3_r == '0) || (dot3_r <= 0)) begin
      mode4_r <= ppf_pkg::TM_ZERO;
    end else if ($signed({1'b0, len3_r}) <= dot3_r) begin
      mode4_r <= ppf_pkg::TM_FULL;
    end else begin
      mode4_r <= ppf_pkg::TM_DIV;
    end
    rem4_r <= dot3_r[SW-1:0];
    len4_r <= len3_r;
    b4_r   <= b3_r;
  end

  // ---------------------------------------------------------------------------------------
  // Divider chain: one quotient bit of t per cell.
  // ---------------------------------------------------------------------------------------
  logic [DIV_STEPS:0]                        dv;
  logic [DIV_STEPS:0][SW-1:0]                drem, dden;
  logic [DIV_STEPS:0][ppf_pkg::Q_BITS-1:0]   dq;
  logic [DIV_STEPS:0][TW-1:0]                dtag;

  assign dv[0]   = s4_v_r;
  assign drem[0] = rem4_r;
  assign dden[0] = len4_r;
  assign dq[0]   = '0;
  assign dtag[0] = {mode4_r, b4_r};

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    ppf_div_cell #(
      .REM_W (SW),
      .TAG_W (TW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_v    (dv[i]),
      .in_rem  (drem[i]),
      .in_den  (dden[i]),
      .in_q    (dq[i]),
      .in_tag  (dtag[i]),
      .out_v   (dv[i+1]),
      .out_rem (drem[i+1]),
      .out_den (dden[i+1]),
      .out_q   (dq[i+1]),
      .out_tag (dtag[i+1])
    );
  end

  // ---------------------------------------------------------------------------------------
  // Back stages: projection offsets, clamped distance components, squares and sums.
  // ---------------------------------------------------------------------------------------
  ppf_pkg::tmode_t             dmode;
  logic [ppf_pkg::T_BITS-1:0]  t5_r;
  logic [CB:0]                 vm5_r [3];
  logic [BW-1:0]               b5_r;
  logic                        s5_v_r;
  logic signed [CB:0]          vd [3];

  assign dmode = ppf_pkg::tmode_t'(dtag[DIV_STEPS][TW-1 -: 2]);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vd[k] = $signed(dtag[DIV_STEPS][OFF_V + k*(CB+1) +: CB+1]);
    end
  end

  always_ff @(posedge clk) begin
    unique case (dmode)
      ppf_pkg::TM_ZERO: t5_r <= '0;
      ppf_pkg::TM_FULL: t5_r <= ppf_pkg::T_ONE;
      ppf_pkg::TM_DIV:  t5_r <= {1'b0, dq[DIV_STEPS]};
      default:          t5_r <= '0;
    endcase
    for (int k = 0; k < 3; k++) begin
      vm5_r[k] <= vd[k][CB] ? unsigned'(-vd[k]) : unsigned'(vd[k]);
    end
    b5_r <= dtag[DIV_STEPS][BW-1:0];
  end

  // Offsets are rounded half away from zero: magnitude rounded, sign put back later.
  logic [CB:0]      off6_r [3];
  logic [LB-1:0]    lp6_r;
  logic [BW-1:0]    b6_r;
  logic             s6_v_r;
  logic [CB+17:0]   offp [3];
  logic [LB+16:0]   lenp;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      offp[k] = (CB+18)'(vm5_r[k] * t5_r) + (CB+18)'(ppf_pkg::T_HALF);
    end
    lenp = b5_r[OFF_LN +: LB] * t5_r;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      off6_r[k] <= offp[k][CB+16:16];
    end
    lp6_r <= lenp[LB+15:16];
    b6_r  <= b5_r;
  end

  logic [ppf_pkg::CLAMP_BITS-1:0]  c7_r [3];
  logic [CHB-1:0]                  ch7_r;
  logic [AW-1:0]                   idx7_r;
  logic                            s7_v_r;
  logic signed [CB+1:0]            dk [3];
  logic signed [CB+1:0]            offs [3];
  logic [MW-1:0]                   dmag [3];
  logic [CHB:0]                    chsum;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      offs[k] = $signed({1'b0, off6_r[k]});
      dk[k]   = (CB+2)'($signed(b6_r[OFF_W + k*(CB+1) +: CB+1]))
              - (b6_r[OFF_V + k*(CB+1) + CB] ? -offs[k] : offs[k]);
      dmag[k] = dk[k][CB+1] ? MW'(unsigned'(-dk[k])) : MW'(unsigned'(dk[k]));
    end
    chsum = (CHB+1)'(b6_r[OFF_CH +: CHB]) + (CHB+1)'(lp6_r);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      c7_r[k] <= (dmag[k] > MW'(ppf_pkg::DIST_CLAMP)) ? ppf_pkg::DIST_CLAMP
                                                      : dmag[k][ppf_pkg::CLAMP_BITS-1:0];
    end
    ch7_r  <= chsum[CHB] ? '1 : chsum[CHB-1:0];
    idx7_r <= b6_r[AW-1:0];
  end

  logic [RADB-1:0]  sq8_r [3];
  logic [QTW-1:0]   t8_r;
  logic             s8_v_r;
  logic [RADB-1:0]  h9_r, s9_r;
  logic [QTW-1:0]   t9_r;
  logic             s9_v_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq8_r[k] <= c7_r[k] * c7_r[k];
    end
    t8_r <= {ch7_r, idx7_r};
    h9_r <= sq8_r[0] + sq8_r[1];
    s9_r <= sq8_r[0] + sq8_r[1] + sq8_r[2];
    t9_r <= t8_r;
  end

  // ---------------------------------------------------------------------------------------
  // Square root chain: one root bit per cell, both distances side by side.
  // ---------------------------------------------------------------------------------------
  logic [SQRT_STEPS:0]                      qv;
  logic [SQRT_STEPS:0][1:0][RADB-1:0]       qrad;
  logic [SQRT_STEPS:0][1:0][RTB+1:0]        qr;
  logic [SQRT_STEPS:0][1:0][RTB-1:0]        qq;
  logic [SQRT_STEPS:0][QTW-1:0]             qtag;

  assign qv[0]   = s9_v_r;
  assign qrad[0] = {s9_r, h9_r};
  assign qr[0]   = '0;
  assign qq[0]   = '0;
  assign qtag[0] = t9_r;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    ppf_sqrt_cell #(
      .TAG_W (QTW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_v    (qv[i]),
      .in_rad  (qrad[i]),
      .in_r    (qr[i]),
      .in_q    (qq[i]),
      .in_tag  (qtag[i]),
      .out_v   (qv[i+1]),
      .out_rad (qrad[i+1]),
      .out_r   (qr[i+1]),
      .out_q   (qq[i+1]),
      .out_tag (qtag[i+1])
    );
  end

  // ---------------------------------------------------------------------------------------
  // Running minimum. Segments leave the chain in index order, so a strict compare keeps the
  // first of equal distances.
  // ---------------------------------------------------------------------------------------
  logic [RTB-1:0]                  root_h, root_3;
  logic [ppf_pkg::DIST_BITS-1:0]   dh_sat, d3_sat;
  logic                            better;

  assign pipe_v = qv[SQRT_STEPS];
  assign root_h = qq[SQRT_STEPS][0];
  assign root_3 = qq[SQRT_STEPS][1];
  assign dh_sat = root_h[RTB-1] ? ppf_pkg::DIST_MAX : root_h[ppf_pkg::DIST_BITS-1:0];
  assign d3_sat = root_3[RTB-1] ? ppf_pkg::DIST_MAX : root_3[ppf_pkg::DIST_BITS-1:0];
  assign better = pipe_v && (!best_found_r || (d3_sat < best_d3_r));

  assign veg = hc_r && ((cls_r == ppf_pkg::CLS_LOW_VEG) || (cls_r == ppf_pkg::CLS_MID_VEG) ||
                        (cls_r == ppf_pkg::CLS_HIGH_VEG) || (cls_r == ppf_pkg::CLS_EXTRA));
  assign keep_now = best_found_r && !(use_cls_r && !veg) &&
                    (best_dh_r <= radius_r) && (best_d3_r <= advisory_r);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ppf_pkg::ST_IDLE;
      n_r          <= '0;
      iss_r        <= '0;
      ret_r        <= '0;
      out_v_r      <= 1'b0;
      best_found_r <= 1'b0;
      s0_v_r       <= 1'b0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      s4_v_r       <= 1'b0;
      s5_v_r       <= 1'b0;
      s6_v_r       <= 1'b0;
      s7_v_r       <= 1'b0;
      s8_v_r       <= 1'b0;
      s9_v_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s0_v_r  <= rd_en;
      s1_v_r  <= s0_v_r;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= dv[DIV_STEPS];
      s6_v_r  <= s5_v_r;
      s7_v_r  <= s6_v_r;
      s8_v_r  <= s7_v_r;
      s9_v_r  <= s8_v_r;
      if (is_point) begin
        n_r          <= n_eff;
        iss_r        <= '0;
        ret_r        <= '0;
        best_found_r <= 1'b0;
      end else begin
        if (rd_en) begin
          iss_r <= iss_r + CW'(1);
        end
        if (pipe_v) begin
          ret_r <= ret_r + CW'(1);
        end
        if (better) begin
          best_found_r <= 1'b1;
        end
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Point, best-so-far and result payload.
  always_ff @(posedge clk) begin
    if (is_point) begin
      px_r      <= in_ch.pos_x;
      py_r      <= in_ch.pos_y;
      pz_r      <= in_ch.pos_z;
      hc_r      <= in_ch.has_class;
      cls_r     <= in_ch.class_code;
      best_idx_r <= '0;
      best_ch_r  <= '0;
      best_dh_r  <= ppf_pkg::DIST_MAX;
      best_d3_r  <= ppf_pkg::DIST_MAX;
    end else if (better) begin
      best_idx_r <= qtag[SQRT_STEPS][AW-1:0];
      best_ch_r  <= qtag[SQRT_STEPS][QTW-1 -: CHB];
      best_dh_r  <= dh_sat;
      best_d3_r  <= d3_sat;
    end
    if (out_load) begin
      o_keep_r  <= keep_now;
      o_found_r <= best_found_r;
      o_idx_r   <= ppf_pkg::SLOT_BITS'(best_idx_r);
      o_ch_r    <= best_ch_r;
      o_dh_r    <= best_dh_r;
      o_d3_r    <= best_d3_r;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.keep           = o_keep_r;
  assign out_ch.found_segment  = o_found_r;
  assign out_ch.best_segment   = o_idx_r;
  assign out_ch.chainage       = o_ch_r;
  assign out_ch.horiz_distance = o_dh_r;
  assign out_ch.dist_3d        = o_d3_r;

endmodule

// ===== test/ppf_checker.sv =====
`timescale 1ns / 1ps

module ppf_checker (
  input  logic          clk,
  input  logic          rst_n,
  ppf_in_if.sink        in_mon,
  ppf_out_if.sink       out_mon,
  input  logic          cfg_wr,
  input  logic [1:0]    cfg_idx,
  input  logic [31:0]   cfg_val,
  output int            fail_count,
  output int            pending,
  output int            results_seen
);

  typedef struct packed {
    logic        keep;
    logic        found;
    logic [5:0]  best;
    logic [31:0] chain;
    logic [23:0] dh;
    logic [23:0] d3;
  } projection_t;

  projection_t expected_q[$];

  // Private copy of the segment table and the registers.
  longint tab_sx[64], tab_sy[64], tab_sz[64], tab_ex[64], tab_ey[64], tab_ez[64];
  longint unsigned tab_ch[64], tab_len[64];
  int unsigned n_segs, radius, advisory;
  bit class_filter;

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned clamp_mag(longint d);
    longint unsigned m;
    m = (d < 0) ? -d : d;
    return (m > 64'h1000000) ? 64'h1000000 : m;
  endfunction

  function automatic projection_t project_point(longint px, longint py, longint pz,
                                                bit hc, logic [7:0] cls);
    projection_t r;
    longint v[3], w[3], d[3];
    logic signed [127:0] len, dot, num;
    longint unsigned t, cx, cy, cz, dh, d3, ch, m;
    int unsigned cnt;
    bit veg;
    r = '0;
    r.dh = ppf_pkg::DIST_MAX;
    r.d3 = ppf_pkg::DIST_MAX;
    cnt = (n_segs > 64) ? 64 : n_segs;
    for (int i = 0; i < cnt; i++) begin
      v[0] = tab_ex[i] - tab_sx[i];
      v[1] = tab_ey[i] - tab_sy[i];
      v[2] = tab_ez[i] - tab_sz[i];
      w[0] = px - tab_sx[i];
      w[1] = py - tab_sy[i];
      w[2] = pz - tab_sz[i];
      len = 0;
      dot = 0;
      for (int k = 0; k < 3; k++) begin
        len += 128'(v[k]) * 128'(v[k]);
        dot += 128'(signed'(w[k])) * 128'(signed'(v[k]));
      end
      if (len == 0 || dot <= 0) t = 0;
      else if (dot >= len) t = 65536;
      else begin
        num = dot <<< 16;
        t = longint'(num / len);
      end
      for (int k = 0; k < 3; k++) begin
        m = (((v[k] < 0) ? -v[k] : v[k]) * t + 32768) >> 16;
        d[k] = w[k] - ((v[k] < 0) ? -longint'(m) : longint'(m));
      end
      cx = clamp_mag(d[0]);
      cy = clamp_mag(d[1]);
      cz = clamp_mag(d[2]);
      dh = isqrt(cx * cx + cy * cy);
      d3 = isqrt(cx * cx + cy * cy + cz * cz);
      if (dh > ppf_pkg::DIST_MAX) dh = ppf_pkg::DIST_MAX;
      if (d3 > ppf_pkg::DIST_MAX) d3 = ppf_pkg::DIST_MAX;
      if (r.found && d3 >= r.d3) continue;
      ch = tab_ch[i] + ((tab_len[i] * t) >> 16);
      if (ch > 64'hFFFFFFFF) ch = 64'hFFFFFFFF;
      r.found = 1'b1;
      r.best = 6'(i);
      r.d3 = 24'(d3);
      r.dh = 24'(dh);
      r.chain = 32'(ch);
    end
    veg = hc && (cls == ppf_pkg::CLS_LOW_VEG || cls == ppf_pkg::CLS_MID_VEG ||
                 cls == ppf_pkg::CLS_HIGH_VEG || cls == ppf_pkg::CLS_EXTRA);
    r.keep = r.found;
    if (class_filter && !veg) r.keep = 1'b0;
    if (r.dh > radius) r.keep = 1'b0;
    if (r.d3 > advisory) r.keep = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    projection_t got, want;
    if (!rst_n) begin
      fail_count = 0;
      results_seen <= 0;
      n_segs = 0;
      radius = 0;
      advisory = 0;
      class_filter = 0;
      expected_q.delete();
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          ppf_pkg::REG_SEG_COUNT: n_segs = 32'(cfg_val[6:0]);
          ppf_pkg::REG_RADIUS:    radius = 32'(cfg_val[23:0]);
          ppf_pkg::REG_ADVISORY:  advisory = 32'(cfg_val[23:0]);
          ppf_pkg::REG_USE_CLASS: class_filter = cfg_val[0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        results_seen <= results_seen + 1;
        got = '{out_mon.keep, out_mon.found_segment, out_mon.best_segment,
                out_mon.chainage, out_mon.horiz_distance, out_mon.dist_3d};
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (got.keep !== want.keep) report_mismatch("keep", got.keep, want.keep);
          if (got.found !== want.found) report_mismatch("found", got.found, want.found);
          if (got.best !== want.best) report_mismatch("best_segment", got.best, want.best);
          if (got.chain !== want.chain) report_mismatch("chainage", got.chain, want.chain);
          if (got.dh !== want.dh) report_mismatch("horiz_distance", got.dh, want.dh);
          if (got.d3 !== want.d3) report_mismatch("dist_3d", got.d3, want.d3);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == ppf_pkg::OP_LOAD) begin
          tab_sx[in_mon.seg_slot] = in_mon.pos_x;
          tab_sy[in_mon.seg_slot] = in_mon.pos_y;
          tab_sz[in_mon.seg_slot] = in_mon.pos_z;
          tab_ex[in_mon.seg_slot] = in_mon.end_x;
          tab_ey[in_mon.seg_slot] = in_mon.end_y;
          tab_ez[in_mon.seg_slot] = in_mon.end_z;
          tab_ch[in_mon.seg_slot] = in_mon.start_chainage;
          tab_len[in_mon.seg_slot] = in_mon.seg_horiz_length;
        end else begin
          expected_q.push_back(project_point(in_mon.pos_x, in_mon.pos_y, in_mon.pos_z,
                                             in_mon.has_class, in_mon.class_code));
        end
      end
    end
  end
endmodule

// ===== test/tb_point_polyline_projection_filter.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the polyline projection filter. The checker beside the
// block predicts every point result and counts mismatches; this module only drives
// beats, register writes and the idle and stall patterns.
module tb_point_polyline_projection_filter;

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [ppf_pkg::CFG_ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic cfg_wr;
  int fail_count, pending, results_seen;
  int send_idle_pct, recv_stall_pct;
  int points_sent;
  bit loaded[64];

  ppf_in_if  in_ch ();
  ppf_out_if out_ch ();

  point_polyline_projection_filter dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // The checker learns a register write at the same edge the block takes it.
  assign cfg_wr = psel && penable && pwrite && pready;

  ppf_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .cfg_wr(cfg_wr), .cfg_idx(paddr[3:2]), .cfg_val(pwdata),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random; the stall rate changes from phase to phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // A write drops psel and penable before it returns, so that the next setup cycle starts on a fresh edge.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Drains all outstanding results, then gives the pipeline time to settle
  // before the registers change.
  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  // One beat on the input channel. Valid stays high across back-to-back beats;
  // idle cycles are inserted before the beat according to the sender idle rate.
  task automatic send_beat(logic op, logic [5:0] slot, logic [23:0] px, logic [23:0] py,
                           logic [23:0] pz, logic [23:0] ex, logic [23:0] ey,
                           logic [23:0] ez, logic [31:0] ch, logic [23:0] len,
                           logic hc, logic [7:0] cls);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.seg_slot <= slot;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.pos_z <= pz;
    in_ch.end_x <= ex;
    in_ch.end_y <= ey;
    in_ch.end_z <= ez;
    in_ch.start_chainage <= ch;
    in_ch.seg_horiz_length <= len;
    in_ch.has_class <= hc;
    in_ch.class_code <= cls;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == ppf_pkg::OP_LOAD) loaded[slot] = 1'b1;
    else points_sent++;
  endtask

  task automatic release_valid();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Coordinates mostly stay in a small region so that projections land inside
  // segments; now and then a full-range value exercises saturation.
  function automatic logic [23:0] rand_coord();
    case ($urandom_range(9))
      0: return 24'($urandom());
      1: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'(int'($urandom_range(40000)) - 20000);
    endcase
  endfunction

  function automatic logic [7:0] rand_class();
    case ($urandom_range(3))
      0: return ppf_pkg::CLS_LOW_VEG;
      1: return $urandom_range(1) ? ppf_pkg::CLS_HIGH_VEG : ppf_pkg::CLS_EXTRA;
      2: return ppf_pkg::CLS_MID_VEG;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic load_segment(logic [5:0] slot);
    send_beat(ppf_pkg::OP_LOAD, slot, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), $urandom_range(3) == 0 ? 32'hFFFF0000 + $urandom()
              % 65536 : $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic send_point();
    send_beat(ppf_pkg::OP_POINT, $urandom(), rand_coord(), rand_coord(), rand_coord(),
              $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              rand_class());
  endtask

  // Segment count never reaches past the slots loaded so far.
  function automatic int loaded_prefix();
    int n;
    n = 0;
    while (n < 64 && loaded[n]) n++;
    return n;
  endfunction

  task automatic random_phase(int items, int idle_pct, int stall_pct);
    int lim;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    wait_drained();
    lim = loaded_prefix();
    // Mostly small counts keep the run short; a few phases search the full table.
    write_reg(ppf_pkg::REG_SEG_COUNT,
              ($urandom_range(4) == 0) ? lim : $urandom_range(lim < 8 ? lim : 8));
    write_reg(ppf_pkg::REG_RADIUS,
              $urandom_range(3) == 0 ? 24'hFFFFFF : $urandom_range(30000));
    write_reg(ppf_pkg::REG_ADVISORY,
              $urandom_range(3) == 0 ? 24'hFFFFFF : $urandom_range(40000));
    write_reg(ppf_pkg::REG_USE_CLASS, $urandom_range(1));
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(9) == 0) load_segment($urandom_range(lim - 1));
      else send_point();
    end
    release_valid();
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = ppf_pkg::OP_LOAD;
    in_ch.seg_slot = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.end_x = '0;
    in_ch.end_y = '0;
    in_ch.end_z = '0;
    in_ch.start_chainage = '0;
    in_ch.seg_horiz_length = '0;
    in_ch.has_class = 1'b0;
    in_ch.class_code = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    points_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: with nothing loaded and count zero, a point reports no segment.
    send_point();
    release_valid();
    wait_drained();

    // Fill the whole table: a zero-length segment, extreme corners, and a
    // chainage that overflows when length is added.
    send_beat(ppf_pkg::OP_LOAD, 6'd0, 24'd100, 24'd100, 24'd100, 24'd100, 24'd100, 24'd100,
              32'd5000, 24'd0, 1'b0, 8'd0);
    send_beat(ppf_pkg::OP_LOAD, 6'd1, 24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF,
              24'h7FFFFF, 24'h7FFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1, 8'hFF);
    send_beat(ppf_pkg::OP_LOAD, 6'd2, 24'd0, 24'd0, 24'd0, 24'd10000, 24'd0, 24'd0,
              32'hFFFFF000, 24'd10000, 1'b0, 8'd0);
    for (int s = 3; s < 64; s++) load_segment(s);
    release_valid();

    write_reg(ppf_pkg::REG_SEG_COUNT, 7'd127);
    write_reg(ppf_pkg::REG_RADIUS, 24'hFFFFFF);
    write_reg(ppf_pkg::REG_ADVISORY, 24'hFFFFFF);
    write_reg(ppf_pkg::REG_USE_CLASS, 1'b1);
    // Before, beyond and inside a segment; extreme points; classes kept and rejected,
    // and a point without a class.
    send_beat(ppf_pkg::OP_POINT, 6'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, '0, '0, '0, '0,
              '0, 1'b1, ppf_pkg::CLS_LOW_VEG);
    send_beat(ppf_pkg::OP_POINT, 6'd63, 24'h800000, 24'h800000, 24'h800000, 24'hFFFFFF,
              24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1, ppf_pkg::CLS_MID_VEG);
    send_beat(ppf_pkg::OP_POINT, 6'd0, -24'sd50, 24'd3, 24'd0, '0, '0, '0, '0, '0, 1'b1,
              ppf_pkg::CLS_HIGH_VEG);
    send_beat(ppf_pkg::OP_POINT, 6'd0, 24'd20000, 24'd3, 24'd0, '0, '0, '0, '0, '0, 1'b1,
              ppf_pkg::CLS_EXTRA);
    send_beat(ppf_pkg::OP_POINT, 6'd0, 24'd4000, 24'd7, 24'd1, '0, '0, '0, '0, '0, 1'b1,
              8'd2);
    send_beat(ppf_pkg::OP_POINT, 6'd0, 24'd100, 24'd100, 24'd100, '0, '0, '0, '0, '0, 1'b0,
              ppf_pkg::CLS_LOW_VEG);
    send_beat(ppf_pkg::OP_POINT, 6'd0, 24'd9999, 24'd0, 24'd0, '0, '0, '0, '0, '0, 1'b1,
              8'hFF);
    release_valid();
    wait_drained();
    write_reg(ppf_pkg::REG_SEG_COUNT, 7'd64);
    write_reg(ppf_pkg::REG_RADIUS, 24'd0);
    write_reg(ppf_pkg::REG_ADVISORY, 24'd0);
    write_reg(ppf_pkg::REG_USE_CLASS, 1'b0);
    send_beat(ppf_pkg::OP_POINT, 6'd0, 24'd100, 24'd100, 24'd100, '0, '0, '0, '0, '0, 1'b0,
              8'd0);
    send_beat(ppf_pkg::OP_POINT, 6'd0, 24'd5000, 24'd1, 24'd0, '0, '0, '0, '0, '0, 1'b0,
              8'd0);
    // A load to an occupied slot between points, on the fly.
    send_beat(ppf_pkg::OP_LOAD, 6'd63, 24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd6, 32'd7,
              24'd8, 1'b0, 8'd0);
    send_beat(ppf_pkg::OP_POINT, 6'd0, 24'd4, 24'd5, 24'd6, '0, '0, '0, '0, '0, 1'b0, 8'd0);
    release_valid();

    // Random: phases over the idle and stall mixes.
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: random_phase(75, 0, 0);
        1: random_phase(75, 76, 0);
        2: random_phase(75, 0, 76);
        default: random_phase(75, 22, 22);
      endcase
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("Covered %0d point beats and %0d result beats over 16 register settings,",
             points_sent, results_seen);
    $display("with sender gaps and receiver stalls mixed in.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
